FILE: design/aspb_pkg.sv
// Shared constants and helpers for the ARGB sprite pixel blend pipeline.
`default_nettype none
package aspb_pkg;

    localparam int unsigned PIX_W  = 32;
    localparam int unsigned ADDR_W = 4;

    typedef logic [2:0] t_op;
    typedef logic [1:0] t_mode;
    typedef logic [1:0] t_reg_idx;

    localparam t_op OP_MUL  = 3'd0;
    localparam t_op OP_KEEP = 3'd1;
    localparam t_op OP_MIX  = 3'd2;
    localparam t_op OP_ADD  = 3'd3;
    localparam t_op OP_SUB  = 3'd4;

    localparam t_mode MODE_OPAQUE = 2'd0;
    localparam t_mode MODE_ALPHA  = 2'd1;
    localparam t_mode MODE_ADD    = 2'd2;

    localparam t_reg_idx REG_COMBINE_OP = 2'd0;
    localparam t_reg_idx REG_BLEND_MODE = 2'd1;
    localparam t_reg_idx REG_COLOUR     = 2'd2;

    localparam t_op   OP_RESET   = OP_KEEP;
    localparam t_mode MODE_RESET = MODE_OPAQUE;

    // 16-bit value read as signed, narrowed to a byte
    function automatic logic [7:0] f_to_byte(input logic [15:0] v);
        logic [7:0] r;
        if (v[15]) begin
            r = 8'd0;
        end else if (v[14:8] != 7'd0) begin
            r = 8'hFF;
        end else begin
            r = v[7:0];
        end
        return r;
    endfunction

    // clamp a 9-bit sum to white
    function automatic logic [7:0] f_sat_white(input logic [8:0] v);
        logic [7:0] r;
        r = v[8] ? 8'hFF : v[7:0];
        return r;
    endfunction

endpackage
`default_nettype wire

FILE: design/argb_sprite_pixel_blend.sv
// ARGB sprite pixel modulate and blend, four-stage pipeline with APB config.
//
// Input stream: s_tdata carries the sprite pixel (bits 31:0) and the destination
// pixel read from the back buffer (bits 63:32). Output stream: m_tdata carries
// the pixel to write back. Every request gives exactly one result.
// Stage 1 forms the combine products, stage 2 the combined bytes, stage 3 the
// blend products, stage 4 the blended pixel into the output register.
// Four register stages, the first loaded at the accepting edge; one pixel per
// cycle sustained while m_tready stays high.
// Each stage advances when the stage after it is empty or moving, so bubbles
// close up and a stalled receiver holds the pipeline without loss.
// s_tready is low only when every stage holds a pixel and m_tready is low.
// Registers over APB: combine_op at 0x0, blend_mode at 0x4, colour_word at 0x8.
// Write them only while the pipeline is empty. An undefined combine_op or
// blend_mode passes the destination pixel through unchanged.
// Reset clears all valid bits and loads combine_op=keep, blend_mode=opaque,
// colour_word=0.
`default_nettype none
module argb_sprite_pixel_blend (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         s_tvalid,
    output logic                        s_tready,
    input  wire  [63:0]                 s_tdata,   // sprite_pixel, dest_pixel
    output logic                        m_tvalid,
    input  wire                         m_tready,
    output logic [31:0]                 m_tdata,   // result_pixel
    input  wire                         psel,
    input  wire                         penable,
    input  wire                         pwrite,
    input  wire  [aspb_pkg::ADDR_W-1:0] paddr,
    input  wire  [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import aspb_pkg::*;

    // configuration
    t_op         r_op;
    t_mode       r_mode;
    logic [31:0] r_colour;
    t_reg_idx    w_idx;
    logic        w_bad_cfg;

    assign pready = 1'b1;
    assign w_idx  = paddr[ADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op     <= OP_RESET;
            r_mode   <= MODE_RESET;
            r_colour <= '0;
        end else if (psel && penable && pwrite && pready) begin
            unique case (w_idx)
                REG_COMBINE_OP: r_op     <= pwdata[2:0];
                REG_BLEND_MODE: r_mode   <= pwdata[1:0];
                REG_COLOUR:     r_colour <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_COMBINE_OP: prdata = {29'd0, r_op};
            REG_BLEND_MODE: prdata = {30'd0, r_mode};
            REG_COLOUR:     prdata = r_colour;
            default:        prdata = '0;
        endcase
    end

    assign w_bad_cfg = (r_op > OP_SUB) || (r_mode > MODE_ADD);

    // colour alpha mixture (sign-extended alpha, packed twice)
    logic [31:0] w_ext, w_packed, w_inverse;
    logic [1:0][15:0] w_keep, w_lose;

    always_comb begin
        w_ext     = {{24{r_colour[31]}}, r_colour[31:24]};
        w_packed  = {w_ext[15:0], 16'd0} | w_ext;
        w_inverse = (w_packed ^ 32'h00FF00FF) << 8;
        w_keep[0] = w_packed[15:0];
        w_keep[1] = w_packed[31:16];
        w_lose[0] = w_inverse[15:0];
        w_lose[1] = w_inverse[31:16];
    end

    // stage enables
    logic r_v1, r_v2, r_v3, r_v4;
    logic w_en1, w_en2, w_en3, w_en4;

    assign w_en4    = !r_v4 || m_tready;
    assign w_en3    = !r_v3 || w_en4;
    assign w_en2    = !r_v2 || w_en3;
    assign w_en1    = !r_v1 || w_en2;
    assign s_tready = w_en1;
    assign m_tvalid = r_v4;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (w_en1) r_v1 <= s_tvalid;
            if (w_en2) r_v2 <= r_v1;
            if (w_en3) r_v3 <= r_v2;
            if (w_en4) r_v4 <= r_v3;
        end
    end

    // stage 1: combine products
    logic [3:0][23:0] n1_kept, n1_lost, r1_kept, r1_lost;
    logic [3:0][15:0] n1_mul, r1_mul;
    logic [31:0]      r1_src, r1_dst;

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            n1_kept[k] = {16'd0, s_tdata[8*k +: 8]} * {8'd0, w_keep[k % 2]};
            n1_lost[k] = {16'd0, r_colour[8*k +: 8]} * {8'd0, w_lose[k % 2]};
            n1_mul[k]  = {8'd0, s_tdata[8*k +: 8]} * {8'd0, r_colour[8*k +: 8]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en1) begin
            r1_kept <= n1_kept;
            r1_lost <= n1_lost;
            r1_mul  <= n1_mul;
            r1_src  <= s_tdata[31:0];
            r1_dst  <= s_tdata[63:32];
        end
    end

    // stage 2: combined bytes
    logic [3:0][15:0] n2_put, r2_put;
    logic [31:0]      r2_dst;

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            logic [7:0]  s, c;
            logic [15:0] kept, lost;
            logic [8:0]  sum;
            s    = r1_src[8*k +: 8];
            c    = r_colour[8*k +: 8];
            kept = r1_kept[k][23:8];
            lost = {8'd0, r1_lost[k][23:16]};
            sum  = {1'b0, s} + {1'b0, c};
            unique case (r_op)
                OP_MUL: n2_put[k] = {8'd0, r1_mul[k][15:8]};
                OP_MIX: begin
                    if (r_mode == MODE_ALPHA) begin
                        n2_put[k] = kept + lost;
                    end else begin
                        n2_put[k] = {8'd0, f_to_byte(kept) + f_to_byte(lost)};
                    end
                end
                OP_ADD:  n2_put[k] = {8'd0, f_sat_white(sum)};
                OP_SUB:  n2_put[k] = {8'd0, (s > c) ? (s - c) : 8'd0};
                default: n2_put[k] = {8'd0, s};
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en2) begin
            r2_put <= n2_put;
            r2_dst <= r1_dst;
        end
    end

    // stage 3: blend products
    logic [3:0][23:0] n3_q1, n3_q2, r3_q1, r3_q2;
    logic [3:0][15:0] r3_put;
    logic [31:0]      r3_dst;
    logic [15:0]      w_inva;

    assign w_inva = r2_put[3] ^ 16'h00FF;

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            n3_q1[k] = {16'd0, r2_put[3][7:0]} * {8'd0, r2_put[k]};
            n3_q2[k] = {16'd0, r2_dst[8*k +: 8]} * {8'd0, w_inva};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en3) begin
            r3_q1  <= n3_q1;
            r3_q2  <= n3_q2;
            r3_put <= r2_put;
            r3_dst <= r2_dst;
        end
    end

    // stage 4: blended pixel
    logic [31:0] n4_pix, r4_pix;

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            logic [7:0]  d;
            logic [15:0] asum;
            logic [8:0]  ssum;
            d    = r3_dst[8*k +: 8];
            asum = r3_q1[k][23:8] + r3_q2[k][23:8];
            ssum = {1'b0, d} + {1'b0, r3_put[k][7:0]};
            if (w_bad_cfg) begin
                n4_pix[8*k +: 8] = d;
            end else begin
                unique case (r_mode)
                    MODE_ALPHA: n4_pix[8*k +: 8] = f_to_byte(asum);
                    MODE_ADD:   n4_pix[8*k +: 8] = f_sat_white(ssum);
                    default:    n4_pix[8*k +: 8] = r3_put[k][7:0];
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en4) begin
            r4_pix <= n4_pix;
        end
    end

    assign m_tdata = r4_pix;

endmodule
`default_nettype wire

FILE: bench/argb_sprite_pixel_blend_tb.sv
// Testbench for argb_sprite_pixel_blend: stream pixels with random config, scoreboard compare.
`default_nettype none
module argb_sprite_pixel_blend_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import aspb_pkg::*;

    localparam t_op      OP_UNDEF_LO  = 3'd5;
    localparam t_op      OP_UNDEF_HI  = 3'd7;
    localparam t_mode    MODE_UNDEF   = 2'd3;
    localparam t_reg_idx REG_SPARE    = 2'd3;
    localparam int       RANDOM_ITEMS = 1950;
    localparam int       CALM_ITEMS   = 250;
    localparam int       STALL_LIMIT  = 1000;

    class blend_scoreboard;
        t_op         op;
        t_mode       mode;
        logic [31:0] color;
        logic [31:0] pixel_q[$];
        int unsigned errors;

        function new();
            op     = OP_RESET;
            mode   = MODE_RESET;
            color  = '0;
            errors = 0;
        endfunction

        function void set_reg(t_reg_idx idx, logic [31:0] value);
            case (idx)
                REG_COMBINE_OP: op    = value[2:0];
                REG_BLEND_MODE: mode  = value[1:0];
                REG_COLOUR:     color = value;
                default: ;
            endcase
        endfunction

        // high half of a 16x16 product
        function logic [15:0] hi16(logic [15:0] a, logic [15:0] b);
            logic [31:0] p;
            p = a * b;
            return p[31:16];
        endfunction

        // 16-bit signed value clamped to a byte
        function logic [7:0] clamp8(logic [15:0] v);
            if (v[15])
                return 8'h00;
            else if (v > 16'h00FF)
                return 8'hFF;
            return v[7:0];
        endfunction

        function logic [31:0] blended_pixel(logic [31:0] spr, logic [31:0] dst);
            logic [31:0] alpha_ext, alpha_pair, alpha_inv, res;
            logic [15:0] keep_h[2], lose_h[2], put[4], kept, lost, a, t;
            logic [7:0]  s, c, d;
            logic [16:0] sum;
            if (op > OP_SUB || mode > MODE_ADD)
                return dst;
            alpha_ext  = {{24{color[31]}}, color[31:24]};
            alpha_pair = (alpha_ext << 16) | alpha_ext;
            alpha_inv  = (alpha_pair ^ 32'h00FF00FF) << 8;
            keep_h[0]  = alpha_pair[15:0];
            keep_h[1]  = alpha_pair[31:16];
            lose_h[0]  = alpha_inv[15:0];
            lose_h[1]  = alpha_inv[31:16];
            for (int k = 0; k < 4; k++) begin
                s = spr[8*k +: 8];
                c = color[8*k +: 8];
                case (op)
                    OP_MUL: put[k] = hi16({s, 8'h00}, {8'h00, c});
                    OP_MIX: begin
                        kept = hi16({s, 8'h00}, keep_h[k % 2]);
                        lost = hi16({8'h00, c}, lose_h[k % 2]);
                        if (mode == MODE_ALPHA)
                            put[k] = kept + lost;
                        else
                            put[k] = {8'h00, 8'(clamp8(kept) + clamp8(lost))};
                    end
                    OP_ADD: begin
                        sum    = s + c;
                        put[k] = (sum > 17'd255) ? 16'h00FF : sum[15:0];
                    end
                    OP_SUB: put[k] = (s > c) ? {8'h00, 8'(s - c)} : 16'h0000;
                    default: put[k] = {8'h00, s};
                endcase
            end
            a = put[3];
            for (int k = 0; k < 4; k++) begin
                d = dst[8*k +: 8];
                case (mode)
                    MODE_ALPHA: begin
                        t = hi16({a[7:0], 8'h00}, put[k]) + hi16({d, 8'h00}, a ^ 16'h00FF);
                        res[8*k +: 8] = clamp8(t);
                    end
                    MODE_ADD: begin
                        sum = d + put[k];
                        res[8*k +: 8] = (sum > 17'd255) ? 8'hFF : sum[7:0];
                    end
                    default: res[8*k +: 8] = put[k][7:0];
                endcase
            end
            return res;
        endfunction

        function void fail(string what, logic [31:0] exp_px, logic [31:0] act_px);
            errors++;
            if (errors <= 10)
                $display("%0t: %s: expected %08h actual %08h", $realtime, what, exp_px, act_px);
        endfunction

        function void note_request(logic [31:0] spr, logic [31:0] dst);
            pixel_q.push_back(blended_pixel(spr, dst));
        endfunction

        function void check_result(logic [31:0] px);
            logic [31:0] exp_px;
            if (pixel_q.size() == 0) begin
                fail("result_pixel with no request pending", 'x, px);
            end else begin
                exp_px = pixel_q.pop_front();
                if (px !== exp_px)
                    fail("result_pixel mismatch", exp_px, px);
            end
        endfunction

        function int pending();
            return pixel_q.size();
        endfunction
    endclass

    logic                i_clk;
    logic                i_rst_n;
    logic                s_tvalid;
    logic                s_tready;
    logic [63:0]         s_tdata;   // sprite_pixel, dest_pixel
    logic                m_tvalid;
    logic                m_tready;
    logic [31:0]         m_tdata;   // result_pixel
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;

    blend_scoreboard sb = new();
    bit              calm = 1'b0;
    int              idle_cycles = 0;

    argb_sprite_pixel_blend uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // receiver backpressure
    initial begin
        int hold;
        hold     = 0;
        m_tready = 1'b1;
        forever begin
            @(negedge i_clk);
            if (hold != 0)
                hold--;
            else if (!calm && $urandom_range(0, 9) == 0)
                hold = $urandom_range(1, 16);
            m_tready <= (hold == 0);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_tvalid && s_tready)
                sb.note_request(s_tdata[31:0], s_tdata[63:32]);
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata);
        end
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("watchdog: no request or result accepted for %0d cycles", STALL_LIMIT);
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic apb_write(t_reg_idx idx, logic [31:0] value);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        sb.set_reg(idx, value);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
    endtask

    // random bits above a register's width
    function automatic logic [31:0] junk_above(int width);
        return ($urandom_range(0, 2) == 0) ? ($urandom << width) : 32'd0;
    endfunction

    task automatic set_config(t_op op, t_mode mode, logic [31:0] color);
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge i_clk);
        apb_write(REG_COMBINE_OP, junk_above(3) | op);
        apb_write(REG_BLEND_MODE, junk_above(2) | mode);
        apb_write(REG_COLOUR, color);
        if ($urandom_range(0, 3) == 0)
            apb_write(REG_SPARE, $urandom);
    endtask

    task automatic send_pixel(logic [31:0] spr, logic [31:0] dst);
        if (!calm && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {dst, spr};
        do @(posedge i_clk); while (s_tready !== 1'b1);
        @(negedge i_clk);
    endtask

    task automatic directed(t_op op, t_mode mode, logic [31:0] color,
                            logic [31:0] spr, logic [31:0] dst);
        set_config(op, mode, color);
        send_pixel(spr, dst);
    endtask

    function automatic logic [31:0] rand_pixel();
        logic [31:0] p;
        p = $urandom;
        if ($urandom_range(0, 3) == 0)
            for (int k = 0; k < 4; k++)
                case ($urandom_range(0, 4))
                    0: p[8*k +: 8] = 8'h00;
                    1: p[8*k +: 8] = 8'hFF;
                    2: p[8*k +: 8] = 8'h7F;
                    3: p[8*k +: 8] = 8'h80;
                    default: ;
                endcase
        return p;
    endfunction

    function automatic logic [31:0] rand_color();
        logic [31:0] c;
        case ($urandom_range(0, 7))
            0: c = 32'h0000_0000;
            1: c = 32'hFFFF_FFFF;
            default: c = rand_pixel();
        endcase
        return c;
    endfunction

    initial begin
        t_op   op;
        t_mode mode;
        int    sent, n;
        i_rst_n  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset config: keep, opaque
        send_pixel(32'hA5C3_0F81, 32'h1234_5678);

        directed(OP_MUL,      MODE_OPAQUE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000);
        directed(OP_MUL,      MODE_ALPHA,  32'h8080_8080, 32'h7F7F_7F7F, 32'hFFFF_FFFF);
        directed(OP_MUL,      MODE_ADD,    32'h1234_5678, 32'hFFFF_FFFF, 32'h8080_8080);
        directed(OP_KEEP,     MODE_OPAQUE, 32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF);
        directed(OP_KEEP,     MODE_ALPHA,  32'h0000_0000, 32'h80FF_0001, 32'h7F00_FF80);
        directed(OP_KEEP,     MODE_ADD,    32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        directed(OP_MIX,      MODE_OPAQUE, 32'hFF00_FF00, 32'hFFFF_FFFF, 32'h0000_0000);
        directed(OP_MIX,      MODE_ALPHA,  32'h80FF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        directed(OP_MIX,      MODE_ADD,    32'h7F80_8080, 32'h0101_0101, 32'hFEFE_FEFE);
        directed(OP_MIX,      MODE_ALPHA,  32'h00FF_FFFF, 32'h0000_0000, 32'h0000_0000);
        directed(OP_MIX,      MODE_OPAQUE, 32'h8000_0000, 32'h8080_8080, 32'h0000_0000);
        directed(OP_MIX,      MODE_ALPHA,  32'hFFFF_FFFF, 32'h1234_5678, 32'h8765_4321);
        directed(OP_ADD,      MODE_OPAQUE, 32'hFFFF_FFFF, 32'h0101_0101, 32'h0000_0000);
        directed(OP_ADD,      MODE_ALPHA,  32'h7F7F_7F7F, 32'h8080_8080, 32'h5A5A_A5A5);
        directed(OP_ADD,      MODE_ADD,    32'h0000_0000, 32'hFFFF_FFFF, 32'h0101_0101);
        directed(OP_SUB,      MODE_OPAQUE, 32'h0101_0101, 32'h0000_0000, 32'hFFFF_FFFF);
        directed(OP_SUB,      MODE_ALPHA,  32'h00FF_00FF, 32'hFFFF_FFFF, 32'h0000_0000);
        directed(OP_SUB,      MODE_ADD,    32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h7F7F_7F7F);
        // undefined codes leave the destination untouched
        directed(OP_UNDEF_LO, MODE_OPAQUE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0F1E_2D3C);
        directed(OP_UNDEF_HI, MODE_ALPHA,  32'h8080_8080, 32'h0000_0000, 32'hC3B2_A190);
        directed(OP_KEEP,     MODE_UNDEF,  32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000);

        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            n = $urandom_range(20, 140);
            if (n > RANDOM_ITEMS - sent)
                n = RANDOM_ITEMS - sent;
            if ($urandom_range(0, 9) == 0)
                op = t_op'($urandom_range(OP_UNDEF_LO, OP_UNDEF_HI));
            else
                op = t_op'($urandom_range(OP_MUL, OP_SUB));
            mode = ($urandom_range(0, 9) == 0) ? MODE_UNDEF
                                                : t_mode'($urandom_range(MODE_OPAQUE, MODE_ADD));
            set_config(op, mode, rand_color());
            calm = (sent >= RANDOM_ITEMS - CALM_ITEMS);
            repeat (n) send_pixel(rand_pixel(), rand_pixel());
            sent += n;
        end

        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge i_clk);
        repeat (8) @(negedge i_clk);
        if (sb.errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
`default_nettype wire

FILE: filelist.f
design/aspb_pkg.sv
design/argb_sprite_pixel_blend.sv
bench/argb_sprite_pixel_blend_tb.sv
